/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LXG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lxg checker: property violated");

// Next-cycle implication, disabled during reset.
`define LXG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lxg checker: property violated");

`endif

/* rtl/core/lxg_pkg.sv */
`default_nettype none

package lxg_pkg;

   // Fixed field widths
   localparam int unsigned WORD_W      = 64;
   localparam int unsigned WORD_SHIFT  = 6;
   localparam int unsigned IDX_W       = 6;
   localparam int unsigned RING_CFG_W  = 7;
   localparam int unsigned SHIFT_W     = 6;
   localparam int unsigned BITS_W      = 13;
   localparam int unsigned MAX_BITS    = 4096;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 13;

   // Defaults for the top-level parameters
   localparam int unsigned DEF_MAX_WORDS        = 64;
   localparam int unsigned DEF_MAX_OUTPUT_WORDS = 64;

   // Command codes
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_GENERATE = 1'b1;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WORDS_IN_USE        = 3'd0,
      CSR_LAG_DISTANCE        = 3'd1,
      CSR_SHIFT_LEFT_FIRST    = 3'd2,
      CSR_SHIFT_RIGHT_FIRST   = 3'd3,
      CSR_SHIFT_LEFT_SECOND   = 3'd4,
      CSR_SHIFT_RIGHT_SECOND  = 3'd5,
      CSR_OUTPUT_BITS         = 3'd6
   } csr_index_type;

   // Register reset values
   localparam logic [RING_CFG_W-1:0] RST_WORDS_IN_USE       = 7'd2;
   localparam logic [SHIFT_W-1:0]    RST_LAG_DISTANCE       = 6'd1;
   localparam logic [SHIFT_W-1:0]    RST_SHIFT_LEFT_FIRST   = 6'd13;
   localparam logic [SHIFT_W-1:0]    RST_SHIFT_RIGHT_FIRST  = 6'd7;
   localparam logic [SHIFT_W-1:0]    RST_SHIFT_LEFT_SECOND  = 6'd17;
   localparam logic [SHIFT_W-1:0]    RST_SHIFT_RIGHT_SECOND = 6'd9;
   localparam logic [BITS_W-1:0]     RST_OUTPUT_BITS        = 13'd64;

   // One xorshift half: v ^= v << sl; v ^= v >> sr
   function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] v,
                                                 input logic [SHIFT_W-1:0] sl,
                                                 input logic [SHIFT_W-1:0] sr);
      logic [WORD_W-1:0] t;
      t = v ^ (v << sl);
      return t ^ (t >> sr);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/lxg_if.sv */
`default_nettype none

// Request channel: one load or generate command per transfer
interface lxg_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [lxg_pkg::IDX_W-1:0]     word_index;
   logic [lxg_pkg::WORD_W-1:0]    seed_word;

   modport source (output valid, command, word_index, seed_word, input ready);
   modport sink   (input valid, command, word_index, seed_word, output ready);
endinterface

// Response channel: one generated word per transfer
interface lxg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lxg_pkg::WORD_W-1:0]    random_word;
   logic                          last_word;

   modport source (output valid, random_word, last_word, input ready);
   modport sink   (input valid, random_word, last_word, output ready);
endinterface

// Register write channel
interface lxg_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lxg_pkg::CSR_IDX_W-1:0]     index;
   logic [lxg_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/lxg_mod_unit.sv */
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module lxg_mod_unit #(
   parameter int unsigned DVD_W = 7,
   parameter int unsigned RW    = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [RW-1:0]    divisor,
   output logic             done,
   output logic [RW-1:0]    remainder
);

   localparam int unsigned CW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [RW-1:0]    dsr_ff, dsr_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [RW:0]      trial;

   // Shift in the next dividend bit, subtract when it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DVD_W);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = RW'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[RW-1:0];
         end
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* rtl/core/lagged_xorshift_generator.sv */
// Lagged xorshift generator. The state is a ring of up to MAX_WORDS 64-bit words held in a
// synchronous two-read, one-write memory; it is undefined after reset and must be seeded with
// load commands before generating (there is no clearing pass). Every command first reduces
// the oldest-word pointer (plus word_index for a load) modulo the ring size in a bit-serial
// remainder unit, one bit per cycle, over max(clog2(MAX_WORDS), 6)+1 bits. A load then writes
// its word. A generate then streams words at one per cycle while the response side keeps up,
// reading the oldest and lagged words and writing each new word back, with forwarding when
// the lagged read hits the word written in that cycle. Results leave through a two-entry
// output queue, most significant word first, the last word flagged. Register writes are taken
// at any time; a command uses the register values seen when it is accepted.
`default_nettype none

module lagged_xorshift_generator #(
   parameter int unsigned MAX_WORDS        = lxg_pkg::DEF_MAX_WORDS,
   parameter int unsigned MAX_OUTPUT_WORDS = lxg_pkg::DEF_MAX_OUTPUT_WORDS
) (
   input  logic       clock,
   input  logic       reset,
   lxg_req_if.sink    req_chan,
   lxg_rsp_if.source  rsp_chan,
   lxg_csr_if.sink    csr_chan
);

   localparam int unsigned WORD_W = lxg_pkg::WORD_W;
   localparam int unsigned SW     = lxg_pkg::SHIFT_W;
   localparam int unsigned PTR_W  = $clog2(MAX_WORDS);
   localparam int unsigned RW     = $clog2(MAX_WORDS + 1);
   localparam int unsigned RCW    = (RW > lxg_pkg::RING_CFG_W) ? RW : lxg_pkg::RING_CFG_W;
   localparam int unsigned LW     = (RW > SW) ? RW : SW;
   localparam int unsigned DVD_W  = ((PTR_W > lxg_pkg::IDX_W) ? PTR_W : lxg_pkg::IDX_W) + 1;
   localparam int unsigned CNT_W  = $clog2(MAX_OUTPUT_WORDS + 1);
   localparam int unsigned WC_W   = lxg_pkg::BITS_W - lxg_pkg::WORD_SHIFT + 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MOD  = 3'b010,
      ST_RUN  = 3'b100
   } state_type;

   // Configuration registers
   logic [lxg_pkg::RING_CFG_W-1:0] wiu_ff;
   logic [SW-1:0]                  lag_ff, sl1_ff, sr1_ff, sl2_ff, sr2_ff;
   logic [lxg_pkg::BITS_W-1:0]     nbits_ff;

   // Control
   state_type        state_ff, state_in;
   logic [PTR_W-1:0] oldest_ptr_ff, oldest_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             first_ff, first_in;
   logic [PTR_W-1:0] rd_p_ff, rd_p_in, rd_q_ff, rd_q_in;

   // Per-command snapshot
   logic                  cmd_ff;
   logic [WORD_W-1:0]     seed_ff;
   logic [RW-1:0]         r_ff, rms_ff;
   logic [SW-1:0]         a_ff, b_ff, c_ff, d_ff;
   logic [SW-1:0]         rem_bits_ff;

   // Ring memory and read stage
   logic [WORD_W-1:0] ring_mem [MAX_WORDS];
   logic [WORD_W-1:0] x_rd_ff, y_rd_ff, w_last_ff;
   logic              fwd_x_ff, fwd_y_ff;
   logic              s1_valid_ff;
   logic [PTR_W-1:0]  s1_addr_ff;
   logic              s1_first_ff, s1_last_ff;

   // Output queue
   logic [WORD_W-1:0] q_word_ff [2];
   logic              q_last_ff [2];
   logic              q_wp_ff, q_rp_ff;
   logic [1:0]        q_cnt_ff;

   // Combinational helpers
   logic                  accept, pop, issue;
   logic [2:0]            occ;
   logic [RCW-1:0]        wiu_ext, r_sat;
   logic [RW-1:0]         r_cur, rms_cur;
   logic [LW-1:0]         lag_ext, lag_lo, r_m1, s_cur;
   logic [lxg_pkg::BITS_W-1:0] n_lo, n_cl;
   logic [lxg_pkg::BITS_W:0]   n_sum;
   logic [WC_W-1:0]       words_full, words_cap;
   logic [DVD_W-1:0]      mod_dividend;
   logic                  mod_done;
   logic [RW-1:0]         mod_rem;
   logic [RW:0]           q_sum;
   logic [RW:0]           q_wrap;
   logic [PTR_W-1:0]      p_next, q_next;
   logic [WORD_W-1:0]     x_op, y_op, w_new, w_out;
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic                  load_wr;

   assign csr_chan.ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         wiu_ff   <= lxg_pkg::RST_WORDS_IN_USE;
         lag_ff   <= lxg_pkg::RST_LAG_DISTANCE;
         sl1_ff   <= lxg_pkg::RST_SHIFT_LEFT_FIRST;
         sr1_ff   <= lxg_pkg::RST_SHIFT_RIGHT_FIRST;
         sl2_ff   <= lxg_pkg::RST_SHIFT_LEFT_SECOND;
         sr2_ff   <= lxg_pkg::RST_SHIFT_RIGHT_SECOND;
         nbits_ff <= lxg_pkg::RST_OUTPUT_BITS;
      end else if (csr_chan.valid) begin
         case (lxg_pkg::csr_index_type'(csr_chan.index))
            lxg_pkg::CSR_WORDS_IN_USE:       wiu_ff   <= csr_chan.data[lxg_pkg::RING_CFG_W-1:0];
            lxg_pkg::CSR_LAG_DISTANCE:       lag_ff   <= csr_chan.data[SW-1:0];
            lxg_pkg::CSR_SHIFT_LEFT_FIRST:   sl1_ff   <= csr_chan.data[SW-1:0];
            lxg_pkg::CSR_SHIFT_RIGHT_FIRST:  sr1_ff   <= csr_chan.data[SW-1:0];
            lxg_pkg::CSR_SHIFT_LEFT_SECOND:  sl2_ff   <= csr_chan.data[SW-1:0];
            lxg_pkg::CSR_SHIFT_RIGHT_SECOND: sr2_ff   <= csr_chan.data[SW-1:0];
            lxg_pkg::CSR_OUTPUT_BITS:        nbits_ff <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // Saturate ring size, lag and bit length
   always_comb begin
      wiu_ext = RCW'(wiu_ff);
      if (wiu_ext < RCW'(2)) begin
         r_sat = RCW'(2);
      end else if (wiu_ext > RCW'(MAX_WORDS)) begin
         r_sat = RCW'(MAX_WORDS);
      end else begin
         r_sat = wiu_ext;
      end
      r_cur   = r_sat[RW-1:0];
      lag_ext = LW'(lag_ff);
      lag_lo  = (lag_ext == '0) ? LW'(1) : lag_ext;
      r_m1    = LW'(r_cur) - LW'(1);
      s_cur   = (lag_lo > r_m1) ? r_m1 : lag_lo;
      rms_cur = r_cur - s_cur[RW-1:0];

      n_lo       = (nbits_ff == '0) ? lxg_pkg::BITS_W'(1) : nbits_ff;
      n_cl       = (n_lo > lxg_pkg::BITS_W'(lxg_pkg::MAX_BITS)) ?
                   lxg_pkg::BITS_W'(lxg_pkg::MAX_BITS) : n_lo;
      n_sum      = (lxg_pkg::BITS_W + 1)'(n_cl) + (lxg_pkg::BITS_W + 1)'(WORD_W - 1);
      words_full = WC_W'(n_sum >> lxg_pkg::WORD_SHIFT);
      words_cap  = (words_full > WC_W'(MAX_OUTPUT_WORDS)) ?
                   WC_W'(MAX_OUTPUT_WORDS) : words_full;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign mod_dividend   = DVD_W'(oldest_ptr_ff) +
                           ((req_chan.command == lxg_pkg::CMD_LOAD) ?
                            DVD_W'(req_chan.word_index) : DVD_W'(0));

   lxg_mod_unit #(
      .DVD_W (DVD_W),
      .RW    (RW)
   ) u_lxg_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (mod_dividend),
      .divisor   (r_cur),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Hold the command and the register values for its whole run
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= req_chan.command;
         seed_ff     <= req_chan.seed_word;
         r_ff        <= r_cur;
         rms_ff      <= rms_cur;
         a_ff        <= sl1_ff;
         b_ff        <= sr1_ff;
         c_ff        <= sl2_ff;
         d_ff        <= sr2_ff;
         rem_bits_ff <= n_cl[SW-1:0];
      end
   end

   // Issue a word only if the queue can still take it when it leaves the read stage
   assign pop   = rsp_chan.valid && rsp_chan.ready;
   assign occ   = 3'(q_cnt_ff) + 3'(s1_valid_ff) - 3'(pop);
   assign issue = (state_ff == ST_RUN) && (cnt_ff != '0) && (occ <= 3'd1);

   // Lagged slot of the first word and pointer advance
   always_comb begin
      q_sum  = (RW + 1)'(mod_rem) + (RW + 1)'(rms_ff);
      q_wrap = (q_sum >= (RW + 1)'(r_ff)) ? (q_sum - (RW + 1)'(r_ff)) : q_sum;
      p_next = ((RW'(rd_p_ff) + RW'(1)) == r_ff) ? '0 : (rd_p_ff + PTR_W'(1));
      q_next = ((RW'(rd_q_ff) + RW'(1)) == r_ff) ? '0 : (rd_q_ff + PTR_W'(1));
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      oldest_ptr_in = oldest_ptr_ff;
      cnt_in        = cnt_ff;
      first_in      = first_ff;
      rd_p_in       = rd_p_ff;
      rd_q_in       = rd_q_ff;
      load_wr       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MOD;
               cnt_in   = CNT_W'(words_cap);
               first_in = 1'b1;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               if (cmd_ff == lxg_pkg::CMD_LOAD) begin
                  load_wr  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  rd_p_in  = mod_rem[PTR_W-1:0];
                  rd_q_in  = q_wrap[PTR_W-1:0];
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               first_in = 1'b0;
               rd_p_in  = p_next;
               rd_q_in  = q_next;
            end else if (cnt_ff == '0 && !s1_valid_ff) begin
               oldest_ptr_in = rd_p_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         oldest_ptr_ff <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         oldest_ptr_ff <= oldest_ptr_in;
         s1_valid_ff   <= issue;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      first_ff <= first_in;
      rd_p_ff  <= rd_p_in;
      rd_q_ff  <= rd_q_in;
   end

   // Combine the oldest and lagged words; forward the word written last cycle
   always_comb begin
      x_op  = fwd_x_ff ? w_last_ff : x_rd_ff;
      y_op  = fwd_y_ff ? w_last_ff : y_rd_ff;
      w_new = lxg_pkg::xs_step(x_op, a_ff, b_ff) ^ lxg_pkg::xs_step(y_op, c_ff, d_ff);
      if (s1_first_ff && rem_bits_ff != '0) begin
         w_out = w_new & ~({WORD_W{1'b1}} << rem_bits_ff);
      end else begin
         w_out = w_new;
      end
   end

   // Single write port: new word in a run, seed word on a load
   assign wr_en   = s1_valid_ff || load_wr;
   assign wr_addr = s1_valid_ff ? s1_addr_ff : mod_rem[PTR_W-1:0];
   assign wr_data = s1_valid_ff ? w_new : seed_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         x_rd_ff <= ring_mem[rd_p_ff];
         y_rd_ff <= ring_mem[rd_q_ff];
      end
   end

   // Read-stage bookkeeping
   always_ff @(posedge clock) begin
      if (issue) begin
         fwd_x_ff    <= s1_valid_ff && (s1_addr_ff == rd_p_ff);
         fwd_y_ff    <= s1_valid_ff && (s1_addr_ff == rd_q_ff);
         s1_addr_ff  <= rd_p_ff;
         s1_first_ff <= first_ff;
         s1_last_ff  <= (cnt_ff == CNT_W'(1));
      end
      if (s1_valid_ff) begin
         w_last_ff <= w_new;
      end
   end

   // Output queue: push from the combine stage, pop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff  <= 1'b0;
         q_rp_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         if (s1_valid_ff) begin
            q_wp_ff <= ~q_wp_ff;
         end
         if (pop) begin
            q_rp_ff <= ~q_rp_ff;
         end
         q_cnt_ff <= q_cnt_ff + 2'(s1_valid_ff) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         q_word_ff[q_wp_ff] <= w_out;
         q_last_ff[q_wp_ff] <= s1_last_ff;
      end
   end

   assign rsp_chan.valid       = (q_cnt_ff != 2'd0);
   assign rsp_chan.random_word = q_word_ff[q_rp_ff];
   assign rsp_chan.last_word   = q_last_ff[q_rp_ff];

endmodule

`default_nettype wire

/* rtl/core/lxg_checker.sv */
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the generator
module lxg_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_command,
   input logic rsp_valid,
   input logic rsp_ready
);

   logic req_xfer;
   logic load_xfer;

   assign req_xfer  = req_valid && req_ready;
   assign load_xfer = req_xfer && (req_command == lxg_pkg::CMD_LOAD);

   // A pending response stays offered until transferred
   `LXG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Nothing is offered right after reset
   `LXG_ASSERT_SAME(a_rsp_reset, clock, reset, $past(reset), !rsp_valid)

   // A command keeps the block busy for at least the next cycle
   `LXG_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_ready)

   // A load never starts a new response
   `LXG_ASSERT_NEXT(a_load_silent, clock, reset, load_xfer, !$rose(rsp_valid))

endmodule

bind lagged_xorshift_generator lxg_checker u_lxg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_command (req_chan.command),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready)
);

`default_nettype wire
